FILE: src/dedge_pkg.sv
package dedge_pkg;

    localparam int PIX_W     = 8;
    localparam int COL_W     = 10;
    localparam int ROW_W     = 12;
    localparam int FW_W      = 11;
    localparam int FH_W      = 12;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

    localparam int MIN_SIZE = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic [PIX_W-1:0] top_left;
        logic [PIX_W-1:0] bot_right;
        logic [PIX_W-1:0] top_right;
        logic [PIX_W-1:0] bot_left;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] bottom;
        logic [PIX_W-1:0] left;
        logic [PIX_W-1:0] right;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } win_t;

    function automatic logic [PIX_W-1:0] absdiff(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
        logic [PIX_W-1:0] d;
        if (a > b)
        begin
            d = a - b;
        end
        else
        begin
            d = b - a;
        end
        return d;
    endfunction

endpackage

FILE: src/dedge_front.sv
module dedge_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [dedge_pkg::PIX_W-1:0]   pixel,
    input  logic                          frame_start,
    input  logic [dedge_pkg::FW_W-1:0]    frame_width,
    input  logic [dedge_pkg::FH_W-1:0]    frame_height,
    output logic                          q_push,
    output dedge_pkg::win_t               q_data,
    input  logic                          q_ready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > dedge_pkg::FW_W) ? CW + 1 : dedge_pkg::FW_W;
    localparam int HW = dedge_pkg::ROW_W + 1;

    logic [dedge_pkg::PIX_W-1:0] upper_mem [MAX_WIDTH];
    logic [dedge_pkg::PIX_W-1:0] lower_mem [MAX_WIDTH];

    logic [CW-1:0]                 col_cnt_reg, col_cnt_next;
    logic [dedge_pkg::ROW_W-1:0]   row_cnt_reg, row_cnt_next;
    logic                          s1_valid_reg, s1_valid_next;
    logic [dedge_pkg::PIX_W-1:0]   win_reg [6];

    logic [dedge_pkg::PIX_W-1:0]   s1_pix_reg;
    logic [CW-1:0]                 s1_x_reg;
    logic [dedge_pkg::COL_W-1:0]   s1_col_reg;
    logic [dedge_pkg::ROW_W-1:0]   s1_row_reg;
    logic                          s1_int_reg;
    logic                          s1_last_reg;
    logic                          byp_reg;
    logic [dedge_pkg::PIX_W-1:0]   byp_up_reg;
    logic [dedge_pkg::PIX_W-1:0]   byp_mid_reg;
    logic [dedge_pkg::PIX_W-1:0]   rd_up_reg;
    logic [dedge_pkg::PIX_W-1:0]   rd_mid_reg;

    logic                          acc;
    logic                          s1_fire;
    logic [CW-1:0]                 x;
    logic [dedge_pkg::ROW_W-1:0]   y;
    logic [WW-1:0]                 fw_ext;
    logic [WW-1:0]                 w_eff;
    logic [WW-1:0]                 xp1;
    logic [dedge_pkg::FH_W-1:0]    h_eff;
    logic [HW-1:0]                 yp1;
    logic                          x_wrap;
    logic                          y_wrap;
    logic [dedge_pkg::PIX_W-1:0]   up_e;
    logic [dedge_pkg::PIX_W-1:0]   mid_e;

    // effective frame size
    always_comb
    begin
        fw_ext = WW'(frame_width);
        if (fw_ext < WW'(dedge_pkg::MIN_SIZE))
        begin
            w_eff = WW'(dedge_pkg::MIN_SIZE);
        end
        else if (fw_ext > WW'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = fw_ext;
        end
        if (frame_height < dedge_pkg::FH_W'(dedge_pkg::MIN_SIZE))
        begin
            h_eff = dedge_pkg::FH_W'(dedge_pkg::MIN_SIZE);
        end
        else
        begin
            h_eff = frame_height;
        end
    end

    assign s1_fire = s1_valid_reg && (!s1_int_reg || q_ready);
    assign full    = s1_valid_reg && !s1_fire;
    assign acc     = push && !full;

    // position of the incoming pixel
    always_comb
    begin
        x      = frame_start ? '0 : col_cnt_reg;
        y      = frame_start ? '0 : row_cnt_reg;
        xp1    = WW'(x) + WW'(1);
        yp1    = HW'(y) + HW'(1);
        x_wrap = xp1 >= w_eff;
        y_wrap = yp1 >= HW'(h_eff);
    end

    always_comb
    begin
        col_cnt_next  = col_cnt_reg;
        row_cnt_next  = row_cnt_reg;
        s1_valid_next = s1_valid_reg;
        if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        if (acc)
        begin
            s1_valid_next = 1'b1;
            if (x_wrap)
            begin
                col_cnt_next = '0;
                row_cnt_next = y_wrap ? '0 : dedge_pkg::ROW_W'(yp1);
            end
            else
            begin
                col_cnt_next = CW'(xp1);
                row_cnt_next = y;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_cnt_reg  <= col_cnt_next;
            row_cnt_reg  <= row_cnt_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // line store data, forwarded when the previous transaction wrote the same column
    assign up_e  = byp_reg ? byp_up_reg  : rd_up_reg;
    assign mid_e = byp_reg ? byp_mid_reg : rd_mid_reg;

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            rd_up_reg  <= upper_mem[x];
            rd_mid_reg <= lower_mem[x];
        end
        if (s1_fire)
        begin
            upper_mem[s1_x_reg] <= mid_e;
            lower_mem[s1_x_reg] <= s1_pix_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_pix_reg  <= pixel;
            s1_x_reg    <= x;
            s1_col_reg  <= dedge_pkg::COL_W'(x - CW'(1));
            s1_row_reg  <= y - dedge_pkg::ROW_W'(1);
            s1_int_reg  <= (x >= CW'(2)) && (y >= dedge_pkg::ROW_W'(2));
            s1_last_reg <= x_wrap && y_wrap;
            byp_reg     <= s1_fire && (s1_x_reg == x);
            byp_up_reg  <= mid_e;
            byp_mid_reg <= s1_pix_reg;
        end
    end

    // window: 0..2 two columns back, 3..5 one column back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_fire)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= up_e;
            win_reg[4] <= mid_e;
            win_reg[5] <= s1_pix_reg;
        end
    end

    assign q_push = s1_fire && s1_int_reg;

    always_comb
    begin
        q_data.top_left  = win_reg[0];
        q_data.bot_right = s1_pix_reg;
        q_data.top_right = up_e;
        q_data.bot_left  = win_reg[2];
        q_data.top       = win_reg[3];
        q_data.bottom    = win_reg[5];
        q_data.left      = win_reg[1];
        q_data.right     = mid_e;
        q_data.col       = s1_col_reg;
        q_data.row       = s1_row_reg;
        q_data.last      = s1_last_reg;
    end

endmodule

FILE: src/dedge_queue.sv
module dedge_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_push,
    input  dedge_pkg::win_t in_data,
    output logic            in_ready,
    output logic            out_valid,
    output dedge_pkg::win_t out_data,
    input  logic            out_take
);

    dedge_pkg::win_t                entry_reg [dedge_pkg::QUEUE_DEPTH];
    logic [dedge_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [dedge_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [dedge_pkg::QPTR_W:0]     count_reg, count_next;
    logic                           do_wr;
    logic                           do_rd;

    assign in_ready  = count_reg != (dedge_pkg::QPTR_W + 1)'(dedge_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = entry_reg[rd_ptr_reg];
    assign do_wr     = in_push && in_ready;
    assign do_rd     = out_take && out_valid;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

FILE: src/dedge_back.sv
module dedge_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  dedge_pkg::win_t               q_data,
    output logic                          q_take,
    output logic                          empty,
    input  logic                          pop,
    output logic [dedge_pkg::PIX_W-1:0]   magnitude,
    output logic [dedge_pkg::COL_W-1:0]   column,
    output logic [dedge_pkg::ROW_W-1:0]   row,
    output logic                          frame_last
);

    logic                          out_valid_reg, out_valid_next;
    logic [dedge_pkg::PIX_W-1:0]   mag_reg;
    logic [dedge_pkg::COL_W-1:0]   col_reg;
    logic [dedge_pkg::ROW_W-1:0]   row_reg;
    logic                          last_reg;

    logic [dedge_pkg::PIX_W-1:0]   d_diag0, d_diag1, d_vert, d_horz;
    logic [dedge_pkg::PIX_W-1:0]   m_a, m_b, mag;

    assign q_take = q_valid && (!out_valid_reg || pop);

    always_comb
    begin
        d_diag0 = dedge_pkg::absdiff(q_data.top_left, q_data.bot_right);
        d_diag1 = dedge_pkg::absdiff(q_data.top_right, q_data.bot_left);
        d_vert  = dedge_pkg::absdiff(q_data.top, q_data.bottom);
        d_horz  = dedge_pkg::absdiff(q_data.left, q_data.right);
        m_a     = (d_diag1 > d_diag0) ? d_diag1 : d_diag0;
        m_b     = (d_horz > d_vert) ? d_horz : d_vert;
        mag     = (m_b > m_a) ? m_b : m_a;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            mag_reg  <= mag;
            col_reg  <= q_data.col;
            row_reg  <= q_data.row;
            last_reg <= q_data.last;
        end
    end

    assign empty      = !out_valid_reg;
    assign magnitude  = mag_reg;
    assign column     = col_reg;
    assign row        = row_reg;
    assign frame_last = last_reg;

endmodule

FILE: src/difference_edge_detect_3x3_unit.sv
// 3x3 difference edge detector. Gray pixels are pushed in raster order, one per
// clock; for every interior pixel the block returns the largest of the four absolute
// differences across the window centre (both diagonals, vertical, horizontal) with
// its column, row and a last-of-frame flag, as soon as the lower-right neighbour has
// been pushed. Border pixels give no result. Sustained rate is one pixel per clock
// while full is low, set by the single read and single write per cycle on each of the
// two line stores (MAX_WIDTH x 8 bit each); a result passes the front end registers,
// the queue and the output register before it can be popped. A four-entry queue sits
// between the line store front end and the output register, so the input keeps going
// for a few pixels while pop is held low. frame_start restarts the counters at column
// 0, row 0; after the last pixel of a frame a new frame starts on its own. Line stores
// are not cleared: results drawn from columns never written since reset or since a
// width increase are undefined. frame_width is used saturated to 3..MAX_WIDTH,
// frame_height below 3 as 3; write them only while the block is idle.
module difference_edge_detect_3x3_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [dedge_pkg::PIX_W-1:0]       pixel,
    input  logic                              frame_start,
    output logic                              empty,
    input  logic                              pop,
    output logic [dedge_pkg::PIX_W-1:0]       magnitude,
    output logic [dedge_pkg::COL_W-1:0]       column,
    output logic [dedge_pkg::ROW_W-1:0]       row,
    output logic                              frame_last,
    input  logic                              cfg_write,
    input  logic [dedge_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dedge_pkg::CFG_W-1:0]       cfg_data
);

    logic [dedge_pkg::FW_W-1:0]   frame_width_reg, frame_width_next;
    logic [dedge_pkg::FH_W-1:0]   frame_height_reg, frame_height_next;

    logic             fq_push;
    logic             fq_ready;
    dedge_pkg::win_t  fq_data;
    logic             qb_valid;
    logic             qb_take;
    dedge_pkg::win_t  qb_data;

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                dedge_pkg::REG_FRAME_WIDTH:
                begin
                    frame_width_next = cfg_data[dedge_pkg::FW_W-1:0];
                end
                dedge_pkg::REG_FRAME_HEIGHT:
                begin
                    frame_height_next = cfg_data[dedge_pkg::FH_W-1:0];
                end
                default:
                begin
                    frame_width_next = frame_width_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= dedge_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= dedge_pkg::FRAME_HEIGHT_RESET;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    dedge_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .pixel        (pixel),
        .frame_start  (frame_start),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .q_push       (fq_push),
        .q_data       (fq_data),
        .q_ready      (fq_ready)
    );

    dedge_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_push   (fq_push),
        .in_data   (fq_data),
        .in_ready  (fq_ready),
        .out_valid (qb_valid),
        .out_data  (qb_data),
        .out_take  (qb_take)
    );

    dedge_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (qb_valid),
        .q_data     (qb_data),
        .q_take     (qb_take),
        .empty      (empty),
        .pop        (pop),
        .magnitude  (magnitude),
        .column     (column),
        .row        (row),
        .frame_last (frame_last)
    );

endmodule

FILE: src/dedge_checker.sv
module dedge_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  logic                              full,
    input  logic                              empty,
    input  logic                              pop,
    input  logic [dedge_pkg::PIX_W-1:0]       magnitude,
    input  logic [dedge_pkg::COL_W-1:0]       column,
    input  logic [dedge_pkg::ROW_W-1:0]       row,
    input  logic                              frame_last
);

    // a waiting result holds until popped
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(magnitude) && $stable(column)
                              && $stable(row) && $stable(frame_last)))
        else $error("waiting result changed before pop");

    // no result comes out for a pixel in column 0 or row 0
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (column != '0 && row != '0))
        else $error("result on a border pixel");

    // back pressure only builds up behind an accepted transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push && !full))
        else $error("full rose with no transaction accepted");

    // input stalls only when the queue and output register are both occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("full with no result waiting");

endmodule

bind difference_edge_detect_3x3_unit dedge_checker u_dedge_checker (.*);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int LINE_MAX      = 1024;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 820;
    localparam int IDLE_PCT      = 18;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic [dedge_pkg::PIX_W-1:0] magnitude;
        logic [dedge_pkg::COL_W-1:0] column;
        logic [dedge_pkg::ROW_W-1:0] row;
        logic                        frame_end;
    } edge_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            push = 1'b0;
    logic                            full;
    logic [dedge_pkg::PIX_W-1:0]     pixel = '0;
    logic                            frame_start = 1'b0;
    logic                            empty;
    logic                            pop = 1'b0;
    logic [dedge_pkg::PIX_W-1:0]     magnitude;
    logic [dedge_pkg::COL_W-1:0]     column;
    logic [dedge_pkg::ROW_W-1:0]     row;
    logic                            frame_last;
    logic                            cfg_write = 1'b0;
    logic [dedge_pkg::CFG_IDX_W-1:0] cfg_index = dedge_pkg::REG_FRAME_WIDTH;
    logic [dedge_pkg::CFG_W-1:0]     cfg_data = '0;

    difference_edge_detect_3x3_unit #(
        .MAX_WIDTH(LINE_MAX)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .pixel(pixel),
        .frame_start(frame_start),
        .empty(empty),
        .pop(pop),
        .magnitude(magnitude),
        .column(column),
        .row(row),
        .frame_last(frame_last),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    logic [dedge_pkg::PIX_W-1:0] upper_line [LINE_MAX];
    logic [dedge_pkg::PIX_W-1:0] lower_line [LINE_MAX];
    logic [dedge_pkg::PIX_W-1:0] window_pix [6];
    int                          col_pos = 0;
    int                          row_pos = 0;
    logic [dedge_pkg::FW_W-1:0]  width_reg = dedge_pkg::FRAME_WIDTH_RESET;
    logic [dedge_pkg::FH_W-1:0]  height_reg = dedge_pkg::FRAME_HEIGHT_RESET;

    edge_result_t pending_edges [$];
    edge_result_t got_edge;
    edge_result_t want_edge;

    bit idle_on = 1'b1;
    int hold_left = 0;
    int stall_count = 0;
    int mismatches = 0;
    int items_sent = 0;
    int results_checked = 0;

    function automatic int pixel_gap(input logic [dedge_pkg::PIX_W-1:0] a,
                                     input logic [dedge_pkg::PIX_W-1:0] b);
        return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    function automatic bit predict_edge(input logic [dedge_pkg::PIX_W-1:0] p,
                                        input logic start, output edge_result_t res);
        int                          w;
        int                          h;
        int                          x;
        int                          y;
        int                          m;
        logic [dedge_pkg::PIX_W-1:0] up;
        logic [dedge_pkg::PIX_W-1:0] mid;
        bit                          hit;
        w = int'(width_reg);
        if (w < dedge_pkg::MIN_SIZE)
        begin
            w = dedge_pkg::MIN_SIZE;
        end
        if (w > LINE_MAX)
        begin
            w = LINE_MAX;
        end
        h = (height_reg < dedge_pkg::MIN_SIZE) ? dedge_pkg::MIN_SIZE : int'(height_reg);
        if (start)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        x = col_pos;
        y = row_pos;
        up = upper_line[x];
        mid = lower_line[x];
        upper_line[x] = mid;
        lower_line[x] = p;
        res = '0;
        hit = (x >= 2) && (y >= 2);
        if (hit)
        begin
            // diagonals, vertical, horizontal across the centre
            m = pixel_gap(window_pix[0], p);
            if (pixel_gap(up, window_pix[2]) > m)
            begin
                m = pixel_gap(up, window_pix[2]);
            end
            if (pixel_gap(window_pix[3], window_pix[5]) > m)
            begin
                m = pixel_gap(window_pix[3], window_pix[5]);
            end
            if (pixel_gap(window_pix[1], mid) > m)
            begin
                m = pixel_gap(window_pix[1], mid);
            end
            res.magnitude = m[dedge_pkg::PIX_W-1:0];
            res.column = dedge_pkg::COL_W'(x - 1);
            res.row = dedge_pkg::ROW_W'(y - 1);
            res.frame_end = (x + 1 >= w) && (y + 1 >= h);
        end
        window_pix[0] = window_pix[3];
        window_pix[1] = window_pix[4];
        window_pix[2] = window_pix[5];
        window_pix[3] = up;
        window_pix[4] = mid;
        window_pix[5] = p;
        if (x + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (y + 1 >= h) ? 0 : ((y + 1) & 12'hFFF);
        end
        else
        begin
            col_pos = x + 1;
        end
        return hit;
    endfunction

    function automatic void report_failure(input string what, input edge_result_t want,
                                           input edge_result_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
        begin
            $display("%0t %s: expected mag %0d col %0d row %0d last %0d,",
                     $time, what, want.magnitude, want.column, want.row, want.frame_end);
            $display("    got mag %0d col %0d row %0d last %0d",
                     got.magnitude, got.column, got.row, got.frame_end);
        end
    endfunction

    function automatic logic [dedge_pkg::PIX_W-1:0] pick_gray();
        int r;
        r = $urandom_range(15);
        if (r == 0)
        begin
            return '0;
        end
        if (r == 1)
        begin
            return '1;
        end
        return dedge_pkg::PIX_W'($urandom_range(255));
    endfunction

    // receiver side
    always @(negedge clk)
    begin
        if (!rst_n || hold_left != 0)
        begin
            pop <= 1'b0;
        end
        else if (!idle_on)
        begin
            pop <= 1'b1;
        end
        else
        begin
            pop <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            results_checked++;
            got_edge = {magnitude, column, row, frame_last};
            if (pending_edges.size() == 0)
            begin
                report_failure("unexpected transaction", '0, got_edge);
            end
            else
            begin
                want_edge = pending_edges.pop_front();
                if (got_edge.magnitude !== want_edge.magnitude
                    || got_edge.column !== want_edge.column
                    || got_edge.row !== want_edge.row
                    || got_edge.frame_end !== want_edge.frame_end)
                begin
                    report_failure("mismatch", want_edge, got_edge);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
        begin
            stall_count <= 0;
        end
        else
        begin
            stall_count <= stall_count + 1;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("FAIL difference_edge_detect_3x3_unit");
                $finish;
            end
        end
    end

    task automatic send_pixel(input logic [dedge_pkg::PIX_W-1:0] value, input logic start);
        edge_result_t res;
        if (idle_on)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                push <= 1'b0;
                @(negedge clk);
            end
        end
        push <= 1'b1;
        pixel <= value;
        frame_start <= start;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        if (predict_edge(value, start, res))
        begin
            pending_edges.push_back(res);
        end
        items_sent++;
        @(negedge clk);
    endtask

    task automatic stream_pixels(input int count, input bit fresh, input int restart_permille);
        logic start;
        for (int i = 0; i < count; i++)
        begin
            start = (fresh && i == 0) || ($urandom_range(999) < restart_permille);
            send_pixel(pick_gray(), start);
        end
    endtask

    task automatic settle_block();
        push <= 1'b0;
        @(negedge clk);
        while (pending_edges.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [dedge_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dedge_pkg::CFG_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx == dedge_pkg::REG_FRAME_WIDTH)
        begin
            width_reg = value[dedge_pkg::FW_W-1:0];
        end
        else
        begin
            height_reg = value[dedge_pkg::FH_W-1:0];
        end
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_frame(input logic [dedge_pkg::CFG_W-1:0] w,
                             input logic [dedge_pkg::CFG_W-1:0] h);
        write_reg(dedge_pkg::REG_FRAME_WIDTH, w);
        write_reg(dedge_pkg::REG_FRAME_HEIGHT, h);
    endtask

    task automatic test_window_pairs();
        logic [dedge_pkg::PIX_W-1:0] pattern [18];
        pattern = '{8'd0,   8'd128, 8'd128,
                    8'd128, 8'd128, 8'd0,
                    8'd128, 8'd30,  8'd255,
                    8'd255, 8'd128, 8'd128,
                    8'd0,   8'd255, 8'd128,
                    8'd128, 8'd128, 8'd255};
        set_frame(12'd3, 12'd6);
        for (int i = 0; i < 18; i++)
        begin
            send_pixel(pattern[i], i == 0);
        end
        // next frame starts without frame_start
        for (int i = 0; i < 9; i++)
        begin
            send_pixel(i[0] ? 8'hFF : 8'h00, 1'b0);
        end
        settle_block();
    endtask

    task automatic test_size_limits();
        set_frame(12'h000, 12'h000);
        stream_pixels(18, 1'b1, 0);
        settle_block();
        set_frame(12'hFFF, 12'd3);
        stream_pixels(300, 1'b1, 0);
        settle_block();
        set_frame(12'd3, 12'hFFF);
        stream_pixels(120, 1'b1, 0);
        settle_block();
    endtask

    task automatic test_shrink_mid_frame();
        set_frame(12'd20, 12'd10);
        stream_pixels(75, 1'b1, 0);
        settle_block();
        write_reg(dedge_pkg::REG_FRAME_WIDTH, 12'd8);
        stream_pixels(30, 1'b0, 0);
        settle_block();
        write_reg(dedge_pkg::REG_FRAME_HEIGHT, 12'd4);
        stream_pixels(60, 1'b0, 0);
        settle_block();
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        set_frame(12'd16, 12'd10);
        stream_pixels(16 * 10 * 2, 1'b1, 0);
        settle_block();
        idle_on = 1'b1;
    endtask

    task automatic test_output_stall();
        set_frame(12'd10, 12'd8);
        hold_left <= HOLD_CYCLES;
        stream_pixels(80, 1'b1, 0);
        settle_block();
    endtask

    task automatic test_random_frames();
        int w;
        int h;
        int count;
        int first;
        int noise;
        int sent;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            w = ($urandom_range(9) == 0) ? $urandom_range(41, 120) : $urandom_range(3, 24);
            h = $urandom_range(3, 8);
            count = w * h * $urandom_range(1, 2);
            if ($urandom_range(3) == 0)
            begin
                count = count - $urandom_range(1, w);
            end
            if (count > RANDOM_ITEMS - sent + 9)
            begin
                count = RANDOM_ITEMS - sent + 9;
            end
            noise = ($urandom_range(4) == 0) ? 20 : 0;
            write_reg(dedge_pkg::REG_FRAME_WIDTH, dedge_pkg::CFG_W'(
                (w == 3 && $urandom_range(1)) ? $urandom_range(0, 2) : w));
            write_reg(dedge_pkg::REG_FRAME_HEIGHT, dedge_pkg::CFG_W'(
                (h == 3 && $urandom_range(1)) ? $urandom_range(0, 2) : h));
            first = ($urandom_range(4) == 0) ? count / 2 : count;
            stream_pixels(first, 1'b1, noise);
            if (first != count)
            begin
                // sender waits for the block to drain mid-frame
                settle_block();
                stream_pixels(count - first, 1'b0, noise);
            end
            sent += count;
            settle_block();
        end
    endtask

    initial
    begin
        for (int i = 0; i < LINE_MAX; i++)
        begin
            upper_line[i] = '0;
            lower_line[i] = '0;
        end
        for (int i = 0; i < 6; i++)
        begin
            window_pix[i] = '0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_window_pairs();
        test_size_limits();
        test_shrink_mid_frame();
        test_back_to_back();
        test_output_stall();
        test_random_frames();

        settle_block();
        if (pending_edges.size() != 0)
        begin
            mismatches += pending_edges.size();
            $display("%0d expected results never arrived", pending_edges.size());
        end
        $display("run covered %0d pixels and %0d checked edge results",
                 items_sent, results_checked);
        $display("small and saturated frame sizes, mid-frame resizing, stalls, %0d mismatches",
                 mismatches);
        if (mismatches == 0)
        begin
            $display("PASS difference_edge_detect_3x3_unit");
        end
        else
        begin
            $display("FAIL difference_edge_detect_3x3_unit");
        end
        $finish;
    end

endmodule
